FILE: rtl/core/bpq_pkg.sv
package bpq_pkg;

    localparam int NUM_ELEMENTS_DEF = 256;
    localparam int MAX_PRIORITY_DEF = 63;

    localparam int FUNC_W = 3;
    localparam int ELEM_W = 8;
    localparam int PRIO_W = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT      = 3'd0,
        FUNC_REMOVE      = 3'd1,
        FUNC_EXTRACT_MIN = 3'd2,
        FUNC_EXTRACT_MAX = 3'd3,
        FUNC_EXTRACT_AT  = 3'd4,
        FUNC_QUERY       = 3'd5
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ELEM_W-1:0] element;
        logic [PRIO_W-1:0] priority_req;
    } in_t;

    typedef struct packed {
        logic [ELEM_W-1:0] result_element;
        logic              result_valid;
        logic [PRIO_W-1:0] result_priority;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD_RD,
        ST_ELEM_RD,
        ST_UNLINK,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_PUSH_LINK,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/core/bucket_priority_queue.sv
// Bucket priority queue: one result transfer for every input transfer.
// Items that touch no memory go straight to the result; query, remove, extract and insert
// walk the memories, and each step waits on a registered read.
// One item at a time: no new input is accepted until its result is in the output register.
// Reset: asynchronous, active low; afterwards a clearing pass over all NUM_ELEMENTS entries
// marks every element as not queued, during which no input is accepted.
module bucket_priority_queue #(
    parameter int NUM_ELEMENTS = bpq_pkg::NUM_ELEMENTS_DEF,
    parameter int MAX_PRIORITY = bpq_pkg::MAX_PRIORITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bpq_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bpq_pkg::out_t out_data
);

    // Element index width, link width (one extra code serves as the NIL link),
    // number of buckets and bucket index width.
    localparam int IDX_W  = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int LINK_W = $clog2(NUM_ELEMENTS + 1);
    localparam int NUM_LV = MAX_PRIORITY + 1;
    localparam int LVL_W  = $clog2(NUM_LV);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_ELEMENTS);

    // ------------------------------------------------------------------
    // Control and item registers.
    // ------------------------------------------------------------------
    bpq_pkg::state_t state_reg, state_next;
    logic [bpq_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [bpq_pkg::ELEM_W-1:0] elem_in_reg, elem_in_next;
    logic [IDX_W-1:0]           e_reg, e_next;
    logic [LVL_W-1:0]           lvl_reg, lvl_next;
    logic [LINK_W-1:0]          link_n_reg, link_n_next;
    logic [NUM_LV-1:0]          map_reg, map_next;
    logic [IDX_W-1:0]           clr_reg, clr_next;
    bpq_pkg::out_t              res_reg, res_next;
    bpq_pkg::out_t              out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Memories: bucket heads, forward links, backward links and the
    // per-element {queued, level} word. All reads are registered.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  head_mem  [NUM_LV];
    logic [LINK_W-1:0] next_mem  [NUM_ELEMENTS];
    logic [LINK_W-1:0] prev_mem  [NUM_ELEMENTS];
    logic [LVL_W:0]    level_mem [NUM_ELEMENTS];

    logic              head_rd_en;
    logic [LVL_W-1:0]  head_rd_addr;
    logic [IDX_W-1:0]  head_rdata_reg;
    logic              head_we;
    logic [LVL_W-1:0]  head_waddr;
    logic [IDX_W-1:0]  head_wdata;

    logic              elem_rd_en;
    logic [IDX_W-1:0]  elem_rd_addr;
    logic [LINK_W-1:0] next_rdata_reg;
    logic [LINK_W-1:0] prev_rdata_reg;
    logic [LVL_W:0]    level_rdata_reg;

    logic              next_we;
    logic [IDX_W-1:0]  next_waddr;
    logic [LINK_W-1:0] next_wdata;
    logic              prev_we;
    logic [IDX_W-1:0]  prev_waddr;
    logic [LINK_W-1:0] prev_wdata;
    logic              level_we;
    logic [IDX_W-1:0]  level_waddr;
    logic [LVL_W:0]    level_wdata;

    always_ff @(posedge clk)
    begin
        if (head_rd_en)
        begin
            head_rdata_reg <= head_mem[head_rd_addr];
        end
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_rd_en)
        begin
            next_rdata_reg  <= next_mem[elem_rd_addr];
            prev_rdata_reg  <= prev_mem[elem_rd_addr];
            level_rdata_reg <= level_mem[elem_rd_addr];
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (level_we)
        begin
            level_mem[level_waddr] <= level_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Minimum and maximum non-empty buckets.
    // ------------------------------------------------------------------
    logic             map_any;
    logic [LVL_W-1:0] min_lvl;
    logic [LVL_W-1:0] max_lvl;

    bpq_prio_enc #(
        .NUM_LEVELS (NUM_LV),
        .LVL_W      (LVL_W)
    ) u_prio_enc (
        .map     (map_reg),
        .any     (map_any),
        .min_lvl (min_lvl),
        .max_lvl (max_lvl)
    );

    // ------------------------------------------------------------------
    // Shared decode.
    // ------------------------------------------------------------------
    logic             in_fire;
    logic             elem_ok;
    logic             prio_ok;
    logic [LVL_W-1:0] prio_lvl;
    logic             is_extract;
    logic             is_insert;
    logic             is_remove;
    logic             rd_queued;
    logic [LVL_W-1:0] rd_lvl;
    logic             do_unlink;
    logic [LINK_W-1:0] push_n;
    logic             out_free;

    assign in_ready   = (state_reg == bpq_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign elem_ok    = (32'(in_data.element) < NUM_ELEMENTS);
    assign prio_ok    = (32'(in_data.priority_req) <= MAX_PRIORITY);
    assign prio_lvl   = LVL_W'(in_data.priority_req);
    assign is_extract = (func_reg == bpq_pkg::FUNC_EXTRACT_MIN) ||
                        (func_reg == bpq_pkg::FUNC_EXTRACT_MAX) ||
                        (func_reg == bpq_pkg::FUNC_EXTRACT_AT);
    assign is_insert  = (func_reg == bpq_pkg::FUNC_INSERT);
    assign is_remove  = (func_reg == bpq_pkg::FUNC_REMOVE);
    assign rd_queued  = level_rdata_reg[LVL_W];
    assign rd_lvl     = level_rdata_reg[LVL_W-1:0];
    // Insert of a queued element moves it, so it unlinks first like a remove.
    assign do_unlink  = rd_queued && (is_extract || is_insert || is_remove);
    assign push_n     = map_reg[lvl_reg] ? LINK_W'(head_rdata_reg) : NIL;
    assign out_free   = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpq_pkg::ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(NUM_ELEMENTS - 1))
                begin
                    state_next = bpq_pkg::ST_IDLE;
                end
            end
            bpq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = bpq_pkg::ST_DONE;
                    case (in_data.func)
                        bpq_pkg::FUNC_INSERT:
                        begin
                            if (elem_ok && prio_ok)
                            begin
                                state_next = bpq_pkg::ST_ELEM_RD;
                            end
                        end
                        bpq_pkg::FUNC_REMOVE, bpq_pkg::FUNC_QUERY:
                        begin
                            if (elem_ok)
                            begin
                                state_next = bpq_pkg::ST_ELEM_RD;
                            end
                        end
                        bpq_pkg::FUNC_EXTRACT_MIN, bpq_pkg::FUNC_EXTRACT_MAX:
                        begin
                            if (map_any)
                            begin
                                state_next = bpq_pkg::ST_HEAD_RD;
                            end
                        end
                        bpq_pkg::FUNC_EXTRACT_AT:
                        begin
                            if (prio_ok && map_reg[prio_lvl])
                            begin
                                state_next = bpq_pkg::ST_HEAD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = bpq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bpq_pkg::ST_HEAD_RD:   state_next = bpq_pkg::ST_ELEM_RD;
            bpq_pkg::ST_ELEM_RD:   state_next = bpq_pkg::ST_UNLINK;
            bpq_pkg::ST_UNLINK:
            begin
                state_next = is_insert ? bpq_pkg::ST_PUSH_RD : bpq_pkg::ST_DONE;
            end
            bpq_pkg::ST_PUSH_RD:   state_next = bpq_pkg::ST_PUSH_WR;
            bpq_pkg::ST_PUSH_WR:
            begin
                state_next = (push_n != NIL) ? bpq_pkg::ST_PUSH_LINK : bpq_pkg::ST_DONE;
            end
            bpq_pkg::ST_PUSH_LINK: state_next = bpq_pkg::ST_DONE;
            bpq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bpq_pkg::ST_IDLE;
                end
            end
            default:               state_next = bpq_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control.
    // ------------------------------------------------------------------
    always_comb
    begin
        func_next      = func_reg;
        elem_in_next   = elem_in_reg;
        e_next         = e_reg;
        lvl_next       = lvl_reg;
        link_n_next    = link_n_reg;
        map_next       = map_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        head_rd_en   = 1'b0;
        head_rd_addr = lvl_reg;
        head_we      = 1'b0;
        head_waddr   = lvl_reg;
        head_wdata   = e_reg;
        elem_rd_en   = 1'b0;
        elem_rd_addr = e_reg;
        next_we      = 1'b0;
        next_waddr   = e_reg;
        next_wdata   = NIL;
        prev_we      = 1'b0;
        prev_waddr   = e_reg;
        prev_wdata   = NIL;
        level_we     = 1'b0;
        level_waddr  = e_reg;
        level_wdata  = '0;

        case (state_reg)
            bpq_pkg::ST_CLEAR:
            begin
                level_we    = 1'b1;
                level_waddr = clr_reg;
                level_wdata = '0;
                clr_next    = clr_reg + 1'b1;
            end
            bpq_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_next    = in_data.func;
                    elem_in_next = in_data.element;
                    e_next       = IDX_W'(in_data.element);
                    res_next.result_element  = in_data.element;
                    res_next.result_valid    = 1'b0;
                    res_next.result_priority = '0;
                    case (in_data.func)
                        bpq_pkg::FUNC_EXTRACT_MIN:
                        begin
                            lvl_next                = min_lvl;
                            res_next.result_element = '0;
                        end
                        bpq_pkg::FUNC_EXTRACT_MAX:
                        begin
                            lvl_next                = max_lvl;
                            res_next.result_element = '0;
                        end
                        bpq_pkg::FUNC_EXTRACT_AT:
                        begin
                            lvl_next                = prio_lvl;
                            res_next.result_element = '0;
                        end
                        default:
                        begin
                            lvl_next = prio_lvl;
                        end
                    endcase
                end
            end
            bpq_pkg::ST_HEAD_RD:
            begin
                head_rd_en   = 1'b1;
                head_rd_addr = lvl_reg;
            end
            bpq_pkg::ST_ELEM_RD:
            begin
                elem_rd_en   = 1'b1;
                elem_rd_addr = is_extract ? head_rdata_reg : e_reg;
                e_next       = elem_rd_addr;
            end
            bpq_pkg::ST_UNLINK:
            begin
                if (do_unlink)
                begin
                    if (prev_rdata_reg == NIL)
                    begin
                        if (next_rdata_reg == NIL)
                        begin
                            map_next[rd_lvl] = 1'b0;
                        end
                        else
                        begin
                            head_we    = 1'b1;
                            head_waddr = rd_lvl;
                            head_wdata = IDX_W'(next_rdata_reg);
                        end
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = IDX_W'(prev_rdata_reg);
                        next_wdata = next_rdata_reg;
                    end
                    if (next_rdata_reg != NIL)
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = IDX_W'(next_rdata_reg);
                        prev_wdata = prev_rdata_reg;
                    end
                    level_we    = 1'b1;
                    level_waddr = e_reg;
                    level_wdata = {1'b0, rd_lvl};
                end
                if (is_insert)
                begin
                    res_next.result_valid    = 1'b1;
                    res_next.result_priority = bpq_pkg::PRIO_W'(lvl_reg);
                end
                else if (is_extract)
                begin
                    res_next.result_element  = bpq_pkg::ELEM_W'(e_reg);
                    res_next.result_valid    = 1'b1;
                    res_next.result_priority = bpq_pkg::PRIO_W'(rd_lvl);
                end
                else if (rd_queued)
                begin
                    // Remove and query of a queued element report its level.
                    res_next.result_valid    = 1'b1;
                    res_next.result_priority = bpq_pkg::PRIO_W'(rd_lvl);
                end
            end
            bpq_pkg::ST_PUSH_RD:
            begin
                head_rd_en   = 1'b1;
                head_rd_addr = lvl_reg;
            end
            bpq_pkg::ST_PUSH_WR:
            begin
                next_we           = 1'b1;
                next_waddr        = e_reg;
                next_wdata        = push_n;
                prev_we           = 1'b1;
                prev_waddr        = e_reg;
                prev_wdata        = NIL;
                head_we           = 1'b1;
                head_waddr        = lvl_reg;
                head_wdata        = e_reg;
                level_we          = 1'b1;
                level_waddr       = e_reg;
                level_wdata       = {1'b1, lvl_reg};
                map_next[lvl_reg] = 1'b1;
                link_n_next       = push_n;
            end
            bpq_pkg::ST_PUSH_LINK:
            begin
                prev_we    = 1'b1;
                prev_waddr = IDX_W'(link_n_reg);
                prev_wdata = LINK_W'(e_reg);
            end
            bpq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpq_pkg::ST_CLEAR;
            map_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        elem_in_reg <= elem_in_next;
        e_reg       <= e_next;
        lvl_reg     <= lvl_next;
        link_n_reg  <= link_n_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    // A transfer starts the sequence, so the input side closes for the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted twice in a row");

    // A finished result waits while the output register is still held.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpq_pkg::ST_DONE) && out_valid_reg && !out_ready
        |=> (state_reg == bpq_pkg::ST_DONE) && $stable(out_reg))
        else $error("result overwrote a held output");

    // The backward link of the old head is patched only when a head existed.
    a_link_real: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpq_pkg::ST_PUSH_LINK) |-> (link_n_reg != NIL))
        else $error("backward link written for an empty bucket");

    // The echoed element register keeps the accepted id while an item is in flight.
    a_elem_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (elem_in_reg == $past(in_data.element)))
        else $error("element id not captured");
`endif

endmodule

FILE: rtl/core/bpq_prio_enc.sv
// Finds the lowest and highest set bit of the non-empty bucket map.
module bpq_prio_enc #(
    parameter int NUM_LEVELS = bpq_pkg::MAX_PRIORITY_DEF + 1,
    parameter int LVL_W      = $clog2(NUM_LEVELS)
) (
    input  logic [NUM_LEVELS-1:0] map,
    output logic                  any,
    output logic [LVL_W-1:0]      min_lvl,
    output logic [LVL_W-1:0]      max_lvl
);

    always_comb
    begin
        any     = |map;
        min_lvl = '0;
        max_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (map[i])
            begin
                min_lvl = LVL_W'(i);
            end
        end
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (map[i])
            begin
                max_lvl = LVL_W'(i);
            end
        end
    end

endmodule

FILE: tb/sv/bucket_priority_queue_tb.sv
`timescale 1ns / 1ps

module bucket_priority_queue_tb;

    localparam int NUM_EL = bpq_pkg::NUM_ELEMENTS_DEF;
    localparam int NUM_LV = bpq_pkg::MAX_PRIORITY_DEF + 1;
    localparam int NIL = NUM_EL;
    localparam int IDLE_LIMIT = 2000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    bpq_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    bpq_pkg::out_t out_data;

    bucket_priority_queue i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // The shadow queue mirrors the block's state.  Each bucket is a linked list
    // with new entries at the front, so the front element is the one an extract pops.
    int   bkt_head [NUM_LV];
    int   nxt [NUM_EL];
    int   prv [NUM_EL];
    int   lvl_of [NUM_EL];
    bit   queued [NUM_EL];
    bit   nonempty [NUM_LV];

    bpq_pkg::out_t pending_results[$];
    int   mismatches;
    int   items_sent;
    int   results_seen;
    int   idle_cycles;
    bit   calm_phase;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void shadow_unlink(input int e);
        int lv;
        int p;
        int n;
        begin
            lv = lvl_of[e];
            p = prv[e];
            n = nxt[e];
            if (p == NIL)
            begin
                if (n == NIL)
                    nonempty[lv] = 1'b0;
                else
                    bkt_head[lv] = n;
            end
            else
                nxt[p] = n;
            if (n != NIL)
                prv[n] = p;
            queued[e] = 1'b0;
        end
    endfunction

    function automatic void shadow_push(input int e, input int lv);
        int n;
        begin
            n = nonempty[lv] ? bkt_head[lv] : NIL;
            nxt[e] = n;
            prv[e] = NIL;
            if (n != NIL)
                prv[n] = e;
            bkt_head[lv] = e;
            nonempty[lv] = 1'b1;
            lvl_of[e] = lv;
            queued[e] = 1'b1;
        end
    endfunction

    // Works out the one result an operation gives and updates the shadow state.
    function automatic bpq_pkg::out_t predict_queue_op(input bpq_pkg::in_t it);
        bpq_pkg::out_t r;
        int   lv;
        int   e;
        begin
            r = '0;
            r.result_element = it.element;
            lv = -1;
            case (it.func)
                bpq_pkg::FUNC_INSERT:
                begin
                    if (queued[it.element])
                        shadow_unlink(int'(it.element));
                    shadow_push(int'(it.element), int'(it.priority_req));
                    r.result_valid = 1'b1;
                    r.result_priority = it.priority_req;
                end
                bpq_pkg::FUNC_REMOVE:
                begin
                    if (queued[it.element])
                    begin
                        r.result_priority = bpq_pkg::PRIO_W'(lvl_of[it.element]);
                        r.result_valid = 1'b1;
                        shadow_unlink(int'(it.element));
                    end
                end
                bpq_pkg::FUNC_QUERY:
                begin
                    if (queued[it.element])
                    begin
                        r.result_valid = 1'b1;
                        r.result_priority = bpq_pkg::PRIO_W'(lvl_of[it.element]);
                    end
                end
                bpq_pkg::FUNC_EXTRACT_MIN, bpq_pkg::FUNC_EXTRACT_MAX,
                bpq_pkg::FUNC_EXTRACT_AT:
                begin
                    r.result_element = '0;
                    if (it.func == bpq_pkg::FUNC_EXTRACT_AT)
                    begin
                        if (nonempty[it.priority_req])
                            lv = int'(it.priority_req);
                    end
                    else if (it.func == bpq_pkg::FUNC_EXTRACT_MIN)
                    begin
                        for (int l = NUM_LV - 1; l >= 0; l--)
                            if (nonempty[l])
                                lv = l;
                    end
                    else
                    begin
                        for (int l = 0; l < NUM_LV; l++)
                            if (nonempty[l])
                                lv = l;
                    end
                    if (lv >= 0)
                    begin
                        e = bkt_head[lv];
                        shadow_unlink(e);
                        r.result_element = bpq_pkg::ELEM_W'(e);
                        r.result_valid = 1'b1;
                        r.result_priority = bpq_pkg::PRIO_W'(lv);
                    end
                end
                default:
                    ;
            endcase
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("MISMATCH at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
            mismatches++;
        end
    endtask

    // Random stall bursts; none once the calm phase begins.
    task automatic maybe_idle_in();
        begin
            if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    endtask

    // Sends one item: raised at a rising edge, held until the transfer happens.
    // Valid stays high on return; the next call or an idle burst decides what follows.
    task automatic send_item(input logic [2:0] f, input int e, input int p);
        bpq_pkg::in_t it;
        begin
            maybe_idle_in();
            it.func = f;
            it.element = bpq_pkg::ELEM_W'(e);
            it.priority_req = bpq_pkg::PRIO_W'(p);
            in_valid <= 1'b1;
            in_data <= it;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            // The transfer happened at this edge; predict in acceptance order.
            pending_results.push_back(predict_queue_op(it));
            items_sent++;
        end
    endtask

    // Result side: random back-pressure, checks each transfer against the oldest expectation.
    initial
    begin
        bpq_pkg::out_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, element",
                                    int'(out_data.result_element), -1);
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (out_data.result_element !== want.result_element)
                        report_mismatch("result_element", int'(out_data.result_element),
                                        int'(want.result_element));
                    if (out_data.result_valid !== want.result_valid)
                        report_mismatch("result_valid", int'(out_data.result_valid),
                                        int'(want.result_valid));
                    if (out_data.result_priority !== want.result_priority)
                        report_mismatch("result_priority", int'(out_data.result_priority),
                                        int'(want.result_priority));
                end
                results_seen++;
            end
            if (!calm_phase && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT + NUM_EL)
            begin
                $display("Timeout: no transfer for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Directed: empty queue, extremes of element and priority, moves,
    // removal of an absent element, empty bucket, unused function codes.
    task automatic test_directed();
        begin
            send_item(bpq_pkg::FUNC_EXTRACT_MIN, 0, 0);
            send_item(bpq_pkg::FUNC_EXTRACT_MAX, 255, 63);
            send_item(bpq_pkg::FUNC_EXTRACT_AT, 0, 63);
            send_item(bpq_pkg::FUNC_REMOVE, 255, 0);
            send_item(bpq_pkg::FUNC_QUERY, 0, 0);
            send_item(bpq_pkg::FUNC_INSERT, 0, 0);
            send_item(bpq_pkg::FUNC_INSERT, 255, 63);
            send_item(bpq_pkg::FUNC_INSERT, 128, 63);
            send_item(bpq_pkg::FUNC_INSERT, 7, 21);
            send_item(bpq_pkg::FUNC_QUERY, 255, 0);
            send_item(bpq_pkg::FUNC_INSERT, 255, 0);
            send_item(bpq_pkg::FUNC_QUERY, 255, 42);
            send_item(bpq_pkg::FUNC_EXTRACT_AT, 0, 21);
            send_item(bpq_pkg::FUNC_EXTRACT_AT, 0, 21);
            send_item(bpq_pkg::FUNC_EXTRACT_MAX, 0, 0);
            send_item(bpq_pkg::FUNC_EXTRACT_MIN, 0, 0);
            send_item(bpq_pkg::FUNC_REMOVE, 0, 0);
            send_item(bpq_pkg::FUNC_REMOVE, 0, 0);
            send_item(3'd6, 170, 42);
            send_item(3'd7, 85, 21);
            send_item(bpq_pkg::FUNC_EXTRACT_MIN, 0, 0);
            send_item(bpq_pkg::FUNC_EXTRACT_MIN, 0, 0);
        end
    endtask

    // Random: mostly a sensible mix that keeps the queue partly full,
    // with noise items; element pool sometimes narrowed so moves are frequent.
    task automatic test_random(input int count, input bit narrow);
        int r;
        int e;
        int p;
        begin
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(0, 99);
                e = narrow ? $urandom_range(0, 15) : $urandom_range(0, 255);
                p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 63);
                if (r < 40)
                    send_item(bpq_pkg::FUNC_INSERT, e, p);
                else if (r < 50)
                    send_item(bpq_pkg::FUNC_REMOVE, e, p);
                else if (r < 62)
                    send_item(bpq_pkg::FUNC_EXTRACT_MIN, e, p);
                else if (r < 74)
                    send_item(bpq_pkg::FUNC_EXTRACT_MAX, e, p);
                else if (r < 84)
                    send_item(bpq_pkg::FUNC_EXTRACT_AT, e, p);
                else if (r < 96)
                    send_item(bpq_pkg::FUNC_QUERY, e, p);
                else
                    send_item(3'($urandom_range(6, 7)), e, p);
            end
        end
    endtask

    // Sends forty extracts, min or max at random, to unwind the bucket lists.
    task automatic test_drain();
        begin
            for (int i = 0; i < 40; i++)
                send_item($urandom_range(0, 1) ? bpq_pkg::FUNC_EXTRACT_MIN
                                               : bpq_pkg::FUNC_EXTRACT_MAX, 0, 0);
        end
    endtask

    initial
    begin
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        calm_phase = 1'b0;
        for (int i = 0; i < NUM_EL; i++)
            queued[i] = 1'b0;
        for (int i = 0; i < NUM_LV; i++)
            nonempty[i] = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(700, 1'b0);
        test_random(500, 1'b1);
        test_drain();
        calm_phase = 1'b1;
        test_random(500, 1'b0);
        test_drain();
        in_valid <= 1'b0;

        // Wait for outstanding results, then watch for stray output.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d operations over all six functions and the unused codes,", items_sent);
        $display("checked %0d results including moves, empty extracts and drains.", results_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
